/* hdl/smv_pkg.sv */
// smv_pkg: shared types and constants for the sliding window median filter
// used by smv_cell and sliding_window_median; no dependencies
`timescale 1ns / 1ps

package smv_pkg;

    // window capacity and derived widths
    localparam int WINDOW_MAX = 64;
    localparam int LEN_W      = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W      = $clog2(WINDOW_MAX);
    localparam int SAMPLE_W   = 32;
    localparam int MEDIAN_W   = SAMPLE_W + 1;
    localparam int CFG_W      = 7;

    // input item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last_sample;
    } in_item_t;

    // result item
    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_x2;
        logic                       is_last;
    } out_item_t;

    // what a cell shows its neighbours
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       gt;
        logic                       ge;
    } nbr_t;

endpackage

/* hdl/smv_cell.sv */
// smv_cell: one slot of the sorted window; removes the oldest sample and
// inserts the new one by trading values with its two neighbours
// depends on smv_pkg
`timescale 1ns / 1ps

module smv_cell (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic                                 valid,
    input  logic                                 full,
    input  logic signed [smv_pkg::SAMPLE_W-1:0]  x,
    input  logic signed [smv_pkg::SAMPLE_W-1:0]  old_value,
    input  smv_pkg::nbr_t                        left,
    input  smv_pkg::nbr_t                        right,
    output smv_pkg::nbr_t                        own
);
    import smv_pkg::*;

    logic signed [SAMPLE_W-1:0] value_reg;
    logic signed [SAMPLE_W-1:0] value_next;
    logic                       gt;
    logic                       ge;
    logic signed [SAMPLE_W-1:0] comp_here;
    logic signed [SAMPLE_W-1:0] comp_left;
    logic                       c_here;
    logic                       c_left;

    // local compares: empty slots count as greater than any sample
    assign gt = !valid || (value_reg > x);
    assign ge = full && valid && (value_reg >= old_value);

    // slot contents once the oldest sample is squeezed out
    assign comp_here = ge ? right.value : value_reg;
    assign c_here    = ge ? right.gt : gt;
    assign comp_left = left.ge ? value_reg : left.value;
    assign c_left    = left.ge ? gt : left.gt;

    // keep, take the new sample, or take the left neighbour
    always_comb
    begin
        if (!c_here)
        begin
            value_next = comp_here;
        end
        else if (!c_left)
        begin
            value_next = x;
        end
        else
        begin
            value_next = comp_left;
        end
    end

    // value register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign own.value = value_reg;
    assign own.gt    = gt;
    assign own.ge    = ge;

endmodule

/* hdl/sliding_window_median.sv */
// Sliding window median filter: using the block
// Samples enter on in_valid/in_ready with in_data; medians leave on
// out_valid/out_ready with out_data. cfg_we writes window_len from cfg_data
// (0 acts as 1, values above 64 act as 64) and empties the window; write it
// only while the block is idle.
// Each sample updates a row of 64 cells that hold the window in sorted order
// in the same cycle it is accepted; the oldest sample comes from an arrival
// ring through the read register old_reg. While the window fills, samples
// are only stored and a new one can be taken every cycle. Once a sample
// gives a median, the median is picked from the row and registered as soon
// as the output register can take it, which raises out_valid; a full window
// takes no new sample until then. in_ready is held low while a median is
// pending, which is the limit on rate.
// If the receiver stalls, the median waits in the output register; the next
// sample is still taken, and the one after waits until out_ready returns.
// A sample flagged last_sample empties the window as it is accepted; a median it gives is still picked.
// Reset leaves the window empty with window_len = 1; no clearing pass.
// depends on smv_pkg and smv_cell
`timescale 1ns / 1ps

module sliding_window_median (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  smv_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output smv_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [smv_pkg::CFG_W-1:0]     cfg_data
);
    import smv_pkg::*;

    logic [CFG_W-1:0]           window_len_reg;
    logic [LEN_W-1:0]           eff_len;
    logic [LEN_W-1:0]           count_reg;
    logic [LEN_W-1:0]           count_next;
    logic [IDX_W-1:0]           ptr_reg;
    logic [IDX_W-1:0]           ptr_next;
    logic                       pend_reg;
    logic                       pend_last_reg;
    logic                       out_valid_reg;
    out_item_t                  out_reg;
    logic signed [SAMPLE_W-1:0] ring [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] old_reg;
    logic [IDX_W-1:0]           wr_addr;
    logic                       accept;
    logic                       full;
    logic                       produced;
    logic                       load_out;
    logic [WINDOW_MAX-1:0]      cell_valid;
    nbr_t                       cell_out [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] cell_val [WINDOW_MAX];
    logic [IDX_W-1:0]           idx_hi;
    logic [IDX_W-1:0]           idx_lo;
    logic signed [MEDIAN_W-1:0] median;

    // effective window length
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (LEN_W'(window_len_reg) > LEN_W'(WINDOW_MAX))
        begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = LEN_W'(window_len_reg);
        end
    end

    // handshake and item classification
    assign in_ready = !pend_reg;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == eff_len);
    assign produced = full || (count_reg + LEN_W'(1) == eff_len);
    assign load_out = pend_reg && (!out_valid_reg || out_ready);

    // fill count and oldest pointer
    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        if (accept)
        begin
            if (full)
            begin
                if (LEN_W'(ptr_reg) == eff_len - LEN_W'(1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            else
            begin
                count_next = count_reg + LEN_W'(1);
                ptr_next   = '0;
            end
            if (in_data.last_sample)
            begin
                count_next = '0;
                ptr_next   = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= CFG_W'(1);
            count_reg      <= '0;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_len_reg <= cfg_data;
                count_reg      <= '0;
                ptr_reg        <= '0;
            end
            else
            begin
                count_reg <= count_next;
                ptr_reg   <= ptr_next;
            end
            if (accept)
            begin
                pend_reg      <= produced;
                pend_last_reg <= in_data.last_sample;
            end
            else if (load_out)
            begin
                pend_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // arrival ring, oldest sample read ahead into old_reg
    assign wr_addr = full ? ptr_reg : count_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring[wr_addr] <= in_data.sample;
        end
        old_reg <= ring[ptr_reg];
    end

    // row of sorted cells
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            nbr_t left_n;
            nbr_t right_n;

            assign cell_valid[gi] = (LEN_W'(gi) < count_reg);
            assign cell_val[gi]   = cell_out[gi].value;

            if (gi == 0)
            begin : g_first
                assign left_n = '{value: '0, gt: 1'b0, ge: 1'b0};
            end
            else
            begin : g_inner_l
                assign left_n = cell_out[gi-1];
            end

            if (gi == WINDOW_MAX - 1)
            begin : g_last
                assign right_n = '{value: '0, gt: 1'b1, ge: 1'b0};
            end
            else
            begin : g_inner_r
                assign right_n = cell_out[gi+1];
            end

            smv_cell u_cell (
                .clk       (clk),
                .en        (accept),
                .valid     (cell_valid[gi]),
                .full      (full),
                .x         (in_data.sample),
                .old_value (old_reg),
                .left      (left_n),
                .right     (right_n),
                .own       (cell_out[gi])
            );
        end
    endgenerate

    // median pick: two middles, or the middle one twice
    assign idx_hi = eff_len[IDX_W:1];
    assign idx_lo = eff_len[0] ? idx_hi : (idx_hi - IDX_W'(1));
    assign median = MEDIAN_W'(cell_val[idx_lo]) + MEDIAN_W'(cell_val[idx_hi]);

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.median_x2 <= median;
            out_reg.is_last   <= pend_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_len)
        else $error("fill count above window length");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LEN_W'(ptr_reg) < eff_len)
        else $error("oldest pointer outside window");

    a_full_gives_median: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full |=> pend_reg)
        else $error("full window item gave no median");

    a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !out_valid_reg |=> out_valid_reg && !pend_reg)
        else $error("pending median not loaded into output register");
`endif

endmodule
